/* rtl/core/vec3_normalize_defines.svh */
// ----------------------------------------------------------------------------
// vec3_normalize assertion macros
// Concurrent check macros for the vector normalizer; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef VEC3_NORMALIZE_DEFINES_SVH
`define VEC3_NORMALIZE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define V3N_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vec3_normalize: check failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define V3N_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vec3_normalize: check failed");
`else
`define V3N_ASSERT_IMPL(lbl, ante, cons)
`define V3N_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/v3n_pkg.sv */
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared widths and stage payload types of the vector normalizer.
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int CompW  = 32;          // input component width
  localparam int RadW   = 64;          // squared length width
  localparam int RootW  = 32;          // length width
  localparam int QuoW   = 31;          // quotient magnitude width
  localparam int ShW    = 5;           // normalize count width
  localparam int Lanes  = 3;

  // Per-vector flags that ride along the whole pipeline
  typedef struct packed {
    logic             zero;
    logic [Lanes-1:0] neg;
  } flags_t;

  // Payload carried beside the square root
  typedef struct packed {
    flags_t                       flags;
    logic [Lanes-1:0][CompW-1:0]  mag;
    logic [ShW-1:0]               sh;
  } meta_t;

endpackage

/* rtl/core/vec3_normalize.sv */
// ----------------------------------------------------------------------------
// vec3_normalize
// Normalizes a Q16.16 3D vector to a Q2.30 unit vector, flagging zero length.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                 flags
//  s_axis   in   tdata: comp_x, comp_y, comp_z (96 bit)  -
//  m_axis   out  tdata: unit_x, unit_y, unit_z (96 bit)  tuser: zero_length
//
//  One vector enters per clock unless a stall has filled every stage; 72
//  register stages: 6 front stages, 32 square-root stages (one root bit
//  each), 2 scaling stages, 31 divider stages (one quotient bit each),
//  1 output. Each stage holds while its successor is full and stalled,
//  so bubbles are squeezed out and a waiting result blocks new transfers only
//  once every stage is full. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "vec3_normalize_defines.svh"

module vec3_normalize (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // comp_x [31:0], comp_y [63:32], comp_z [95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // unit_x [31:0], unit_y [63:32], unit_z [95:64]
  output logic        m_axis_tuser    // zero_length [0]
);
  import v3n_pkg::*;

  localparam logic signed [CompW-1:0] OneQ    = 32'sh4000_0000;
  localparam logic signed [CompW-1:0] NegOneQ = -32'sh4000_0000;

  // Leading zero count of a 16-bit chunk
  function automatic logic [3:0] clz16(input logic [15:0] v);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        cnt = 4'(15 - i);
      end
    end
    return cnt;
  endfunction

  // ---- stage 1: magnitudes and signs
  logic                        v1_q, rdy1;
  flags_t                      f1_q;
  logic [Lanes-1:0][CompW-1:0] mag1_q;
  // ---- stage 2: squares
  logic                        v2_q, rdy2;
  flags_t                      f2_q;
  logic [Lanes-1:0][CompW-1:0] mag2_q;
  logic [Lanes-1:0][RadW-1:0]  sq2_q;
  // ---- stage 3: sum of squares
  logic                        v3_q, rdy3;
  flags_t                      f3_q;
  logic [Lanes-1:0][CompW-1:0] mag3_q;
  logic [RadW-1:0]             sum3_q;
  // ---- stage 4: chunk leading zeros
  logic                        v4_q, rdy4;
  flags_t                      f4_q;
  logic [Lanes-1:0][CompW-1:0] mag4_q;
  logic [RadW-1:0]             sum4_q;
  logic [3:0]                  zf4_q;
  logic [3:0][3:0]             clz4_q;
  // ---- stage 5: normalize count
  logic                        v5_q, rdy5;
  flags_t                      f5_q;
  logic [Lanes-1:0][CompW-1:0] mag5_q;
  logic [RadW-1:0]             sum5_q;
  logic [ShW-1:0]              sh5_q;
  // ---- stage 6: normalized radicand
  logic                        v6_q, rdy6;
  meta_t                       meta6_q;
  logic [RadW-1:0]             rad6_q;
  // ---- square root
  logic                        sq_in_rdy, sq_out_vld;
  logic [RootW-1:0]            sq_root;
  meta_t                       sq_meta;
  // ---- stage 7: scaled magnitudes
  logic                        v7_q, rdy7;
  flags_t                      f7_q;
  logic [Lanes-1:0][RootW-1:0] p7_q;
  logic [RootW-1:0]            len7_q;
  // ---- stage 8: rounded dividends
  logic                        v8_q, rdy8;
  flags_t                      f8_q;
  logic [Lanes-1:0][RootW-1:0] rem8_q;
  logic [Lanes-1:0][QuoW-1:0]  low8_q;
  logic [RootW-1:0]            len8_q;
  // ---- divider and output
  logic                        dv_in_rdy, dv_out_vld;
  logic [Lanes-1:0][QuoW-1:0]  dv_quo;
  flags_t                      dv_flags;
  logic                        vo_q, rdyo;
  logic [Lanes-1:0][CompW-1:0] unit_q;
  logic                        zero_q;

  // combinational helpers
  logic [Lanes-1:0][CompW-1:0] comp_in, mag1_d;
  logic [Lanes-1:0]            neg1_d;
  logic [3:0]                  zf4_d;
  logic [3:0][3:0]             clz4_d;
  logic [5:0]                  lz5_d;
  logic [Lanes-1:0][RootW-1:0] p7_d;
  logic [Lanes-1:0][61:0]      num8_d;
  logic [Lanes-1:0][CompW-1:0] unit_d;

  // Ready chain from the output back to the input
  assign rdyo = !vo_q || m_axis_tready;
  assign rdy8 = !v8_q || dv_in_rdy;
  assign rdy7 = !v7_q || rdy8;
  assign rdy6 = !v6_q || sq_in_rdy;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= sq_out_vld;
      if (rdy8) v8_q <= v7_q;
      if (rdyo) vo_q <= dv_out_vld;
    end
  end

  // Split the input and take magnitudes
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      comp_in[i] = s_axis_tdata[i*CompW +: CompW];
      neg1_d[i]  = comp_in[i][CompW-1];
      mag1_d[i]  = neg1_d[i] ? (~comp_in[i] + 1'b1) : comp_in[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      mag1_q     <= mag1_d;
      f1_q.neg   <= neg1_d;
      f1_q.zero  <= (s_axis_tdata == '0);
    end
  end

  // Square each magnitude
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int i = 0; i < Lanes; i++) begin
        sq2_q[i] <= {32'd0, mag1_q[i]} * {32'd0, mag1_q[i]};
      end
      mag2_q <= mag1_q;
      f2_q   <= f1_q;
    end
  end

  // Add the squares
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sum3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      mag3_q <= mag2_q;
      f3_q   <= f2_q;
    end
  end

  // Count leading zeros per 16-bit chunk
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      zf4_d[c]  = (sum3_q[c*16 +: 16] == '0);
      clz4_d[c] = clz16(sum3_q[c*16 +: 16]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      zf4_q  <= zf4_d;
      clz4_q <= clz4_d;
      sum4_q <= sum3_q;
      mag4_q <= mag3_q;
      f4_q   <= f3_q;
    end
  end

  // Combine chunk counts; the shift count is half the leading zeros
  always_comb begin
    priority if (!zf4_q[3]) begin
      lz5_d = {2'b00, clz4_q[3]};
    end else if (!zf4_q[2]) begin
      lz5_d = 6'd16 + {2'b00, clz4_q[2]};
    end else if (!zf4_q[1]) begin
      lz5_d = 6'd32 + {2'b00, clz4_q[1]};
    end else begin
      lz5_d = 6'd48 + {2'b00, clz4_q[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      sh5_q  <= lz5_d[5:1];
      sum5_q <= sum4_q;
      mag5_q <= mag4_q;
      f5_q   <= f4_q;
    end
  end

  // Normalize the radicand by an even shift
  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      rad6_q        <= sum5_q << {sh5_q, 1'b0};
      meta6_q.flags <= f5_q;
      meta6_q.mag   <= mag5_q;
      meta6_q.sh    <= sh5_q;
    end
  end

  v3n_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v6_q),
    .in_ready_o  (sq_in_rdy),
    .in_rad_i    (rad6_q),
    .in_meta_i   (meta6_q),
    .out_valid_o (sq_out_vld),
    .out_ready_i (rdy7),
    .out_root_o  (sq_root),
    .out_meta_o  (sq_meta)
  );

  // Scale each magnitude like the length
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      p7_d[i] = RootW'({32'd0, sq_meta.mag[i]} << sq_meta.sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy7 && sq_out_vld) begin
      p7_q   <= p7_d;
      len7_q <= sq_root;
      f7_q   <= sq_meta.flags;
    end
  end

  // Form the dividend with half the length added for rounding
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      num8_d[i] = {p7_q[i], 30'd0} + {31'd0, len7_q[RootW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy8 && v7_q) begin
      for (int i = 0; i < Lanes; i++) begin
        rem8_q[i] <= {1'b0, num8_d[i][61:31]};
        low8_q[i] <= num8_d[i][30:0];
      end
      len8_q <= len7_q;
      f8_q   <= f7_q;
    end
  end

  v3n_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v8_q),
    .in_ready_o  (dv_in_rdy),
    .in_rem_i    (rem8_q),
    .in_low_i    (low8_q),
    .in_len_i    (len8_q),
    .in_flags_i  (f8_q),
    .out_valid_o (dv_out_vld),
    .out_ready_i (rdyo),
    .out_quo_o   (dv_quo),
    .out_flags_o (dv_flags)
  );

  // Apply signs, force zero for a zero-length vector
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      if (dv_flags.zero) begin
        unit_d[i] = '0;
      end else if (dv_flags.neg[i]) begin
        unit_d[i] = ~{1'b0, dv_quo[i]} + 1'b1;
      end else begin
        unit_d[i] = {1'b0, dv_quo[i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyo && dv_out_vld) begin
      unit_q <= unit_d;
      zero_q <= dv_flags.zero;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = unit_q;
  assign m_axis_tuser  = zero_q;

  // Checks
  `V3N_ASSERT_NEXT(a_take_fills_first, s_axis_tvalid && s_axis_tready, v1_q)
  `V3N_ASSERT_IMPL(a_zero_flag_data, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `V3N_ASSERT_IMPL(a_nonzero_has_dir, m_axis_tvalid && !m_axis_tuser, m_axis_tdata != '0)
  `V3N_ASSERT_IMPL(a_unit_range, m_axis_tvalid, ($signed(unit_q[0]) <= OneQ) && ($signed(unit_q[0]) >= NegOneQ) && ($signed(unit_q[1]) <= OneQ) && ($signed(unit_q[1]) >= NegOneQ) && ($signed(unit_q[2]) <= OneQ) && ($signed(unit_q[2]) >= NegOneQ))

endmodule

/* rtl/core/v3n_sqrt.sv */
// ----------------------------------------------------------------------------
// v3n_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module v3n_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [63:0]           in_rad_i,
  input  v3n_pkg::meta_t        in_meta_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           out_root_o,
  output v3n_pkg::meta_t        out_meta_o
);
  import v3n_pkg::*;

  localparam int Steps = RootW;
  localparam int RemW  = RootW + 3;

  logic [Steps-1:0] vld_q;
  logic [Steps-1:0] vld_in;
  logic [Steps:0]   rdy;

  logic [RemW-1:0]  rem_in  [Steps];
  logic [RootW-1:0] root_in [Steps];
  logic [RadW-1:0]  rad_in  [Steps];
  meta_t            meta_in [Steps];

  logic [RemW-1:0]  rem_q  [Steps-1];
  logic [RadW-1:0]  rad_q  [Steps-1];
  logic [RootW-1:0] root_q [Steps];
  meta_t            meta_q [Steps];

  assign rdy[Steps]  = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Steps-1];
  assign out_root_o  = root_q[Steps-1];
  assign out_meta_o  = meta_q[Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] rem_dif;
    logic            ge;

    // Stage advances when empty or when the next one takes its item
    assign rdy[k] = !vld_q[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign vld_in[k]  = in_valid_i;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign rad_in[k]  = in_rad_i;
      assign meta_in[k] = in_meta_i;
    end else begin : g_next
      assign vld_in[k]  = vld_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign rad_in[k]  = rad_q[k-1];
      assign meta_in[k] = meta_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh  = {rem_in[k][RemW-3:0], rad_in[k][RadW-1 -: 2]};
    assign trial   = {1'b0, root_in[k], 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_dif = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in[k]) begin
        root_q[k] <= {root_in[k][RootW-2:0], ge};
        meta_q[k] <= meta_in[k];
      end
    end

    if (k < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (rdy[k] && vld_in[k]) begin
          rem_q[k] <= ge ? rem_dif : rem_sh;
          rad_q[k] <= {rad_in[k][RadW-3:0], 2'b00};
        end
      end
    end
  end

endmodule

/* rtl/core/v3n_div.sv */
// ----------------------------------------------------------------------------
// v3n_div
// Three-lane pipelined restoring divider by a shared length, one bit a stage.
// ----------------------------------------------------------------------------
module v3n_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0][31:0]       in_rem_i,
  input  logic [2:0][30:0]       in_low_i,
  input  logic [31:0]            in_len_i,
  input  v3n_pkg::flags_t        in_flags_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0][30:0]       out_quo_o,
  output v3n_pkg::flags_t        out_flags_o
);
  import v3n_pkg::*;

  localparam int Steps = QuoW;

  logic [Steps-1:0] vld_q;
  logic [Steps-1:0] vld_in;
  logic [Steps:0]   rdy;

  logic [Lanes-1:0][RootW-1:0] rem_in  [Steps];
  logic [Lanes-1:0][QuoW-1:0]  low_in  [Steps];
  logic [Lanes-1:0][QuoW-1:0]  quo_in  [Steps];
  logic [RootW-1:0]            len_in  [Steps];
  flags_t                      flg_in  [Steps];

  logic [Lanes-1:0][RootW-1:0] rem_q [Steps-1];
  logic [Lanes-1:0][QuoW-1:0]  low_q [Steps-1];
  logic [RootW-1:0]            len_q [Steps-1];
  logic [Lanes-1:0][QuoW-1:0]  quo_q [Steps];
  flags_t                      flg_q [Steps];

  assign rdy[Steps]  = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Steps-1];
  assign out_quo_o   = quo_q[Steps-1];
  assign out_flags_o = flg_q[Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [Lanes-1:0][RootW:0]   rem_sh;
    logic [Lanes-1:0][RootW-1:0] rem_nx;
    logic [Lanes-1:0]            ge;

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign vld_in[k] = in_valid_i;
      assign rem_in[k] = in_rem_i;
      assign low_in[k] = in_low_i;
      assign quo_in[k] = '0;
      assign len_in[k] = in_len_i;
      assign flg_in[k] = in_flags_i;
    end else begin : g_next
      assign vld_in[k] = vld_q[k-1];
      assign rem_in[k] = rem_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign len_in[k] = len_q[k-1];
      assign flg_in[k] = flg_q[k-1];
    end

    // Shift in the next dividend bit and subtract the length where it fits
    always_comb begin
      for (int i = 0; i < Lanes; i++) begin
        rem_sh[i] = {rem_in[k][i], low_in[k][i][QuoW-1]};
        ge[i]     = (rem_sh[i] >= {1'b0, len_in[k]});
        rem_nx[i] = ge[i] ? RootW'(rem_sh[i] - {1'b0, len_in[k]})
                          : rem_sh[i][RootW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in[k]) begin
        for (int i = 0; i < Lanes; i++) begin
          quo_q[k][i] <= {quo_in[k][i][QuoW-2:0], ge[i]};
        end
        flg_q[k] <= flg_in[k];
      end
    end

    if (k < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (rdy[k] && vld_in[k]) begin
          for (int i = 0; i < Lanes; i++) begin
            rem_q[k][i] <= rem_nx[i];
            low_q[k][i] <= {low_in[k][i][QuoW-2:0], 1'b0};
          end
          len_q[k] <= len_in[k];
        end
      end
    end
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vec3_normalize: drives Q16.16 vectors with random
// gaps, predicts the Q2.30 unit vector and zero flag, checks every transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // comp_x [31:0], comp_y [63:32], comp_z [95:64]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // unit_x [31:0], unit_y [63:32], unit_z [95:64]
  logic        m_axis_tuser;   // zero_length [0]

  typedef struct packed {
    logic        zero;
    logic [95:0] unit;
  } unit_vec_t;

  unit_vec_t unit_q[$];
  int        err_cnt;
  int        sent_cnt;
  int        recv_cnt;
  int        idle_cnt;
  int        hold_off;
  bit        rx_random;

  vec3_normalize uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Floor square root of a 64-bit value, one root bit per pass
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bit_w;
    root  = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v    = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Expected unit vector for one Q16.16 input vector
  function automatic unit_vec_t normalize_vec(logic [95:0] comps);
    unit_vec_t   res;
    logic [63:0] mag [3];
    logic [63:0] sq;
    logic [63:0] len;
    logic [63:0] quo;
    logic [31:0] c;
    int          h;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      c      = comps[32*i +: 32];
      mag[i] = c[31] ? {32'd0, -c} : {32'd0, c};
      if (c == 32'h8000_0000) mag[i] = 64'h8000_0000;
    end
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
      res.zero = 1'b1;
      return res;
    end
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    h  = 0;
    while (sq < (64'd1 << 62)) begin
      sq = sq << 2;
      h++;
    end
    len = floor_root(sq);
    for (int i = 0; i < 3; i++) begin
      quo = (((mag[i] << h) << 30) + (len >> 1)) / len;
      if (comps[32*i + 31]) quo = -quo;
      res.unit[32*i +: 32] = quo[31:0];
    end
    return res;
  endfunction

  // Offer one vector after a random gap, predict it when the transfer happens
  task automatic send_vec(logic [95:0] comps, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= comps;
    do @(posedge clk_i); while (!s_axis_tready);
    unit_q.push_back(normalize_vec(comps));
    sent_cnt++;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) - 1;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    send_vec({32'd0, 32'd0, 32'd0});
    send_vec({32'd0, 32'd0, one});
    send_vec({32'd0, -one, 32'd0});
    send_vec({32'h8000_0000, 32'd0, 32'd0});
    send_vec({32'd0, 32'd0, 32'h7fff_ffff});
    send_vec({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vec({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_vec({32'd0, 32'd0, 32'd1});
    send_vec({32'hffff_ffff, 32'd0, 32'd0});
    send_vec({32'd1, 32'hffff_ffff, 32'd1});
    send_vec({32'h8000_0000, 32'h7fff_ffff, 32'd1});
    send_vec({one * 2, one * 2, one});
    send_vec({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_vec({32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f});
  endtask

  task automatic test_random();
    for (int i = 0; i < 536; i++)
      send_vec({rand_comp(), rand_comp(), rand_comp()});
  endtask

  // Receiver stops for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 100; i++)
      send_vec({rand_comp(), rand_comp(), rand_comp()}, 1);
  endtask

  // Receiver ready: random wait per result, always ready once random mode is off, or a long hold when asked
  initial begin
    int rx_gap;
    m_axis_tready = 1'b0;
    rx_gap        = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off--;
      end else if (!rx_random) begin
        m_axis_tready <= 1'b1;
      end else if (m_axis_tready && m_axis_tvalid) begin
        rx_gap = $urandom_range(0, 15);
        m_axis_tready <= (rx_gap == 0);
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= (rx_gap == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      recv_cnt <= recv_cnt + 1;
      if (unit_q.size() == 0) begin
        $display("%0t: unexpected result unit=%h zero=%b", $time, m_axis_tdata,
                 m_axis_tuser);
        err_cnt++;
      end else begin
        unit_vec_t exp_v;
        exp_v = unit_q.pop_front();
        for (int i = 0; i < 3; i++)
          if (m_axis_tdata[32*i +: 32] !== exp_v.unit[32*i +: 32]) begin
            $display("%0t: unit[%0d] expected %h actual %h", $time, i,
                     exp_v.unit[32*i +: 32], m_axis_tdata[32*i +: 32]);
            err_cnt++;
          end
        if (m_axis_tuser !== exp_v.zero) begin
          $display("%0t: zero_length expected %b actual %b", $time, exp_v.zero,
                   m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || hold_off > 0)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    err_cnt       = 0;
    sent_cnt      = 0;
    recv_cnt      = 0;
    idle_cnt      = 0;
    hold_off      = 0;
    rx_random     = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    rx_random = 1'b0;
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d vectors in, %0d results out: axes, extremes, zero,",
             sent_cnt, recv_cnt);
    $display("random components, random gaps and a long output stall.");
    if (err_cnt == 0 && unit_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* vec3_normalize.f */
+incdir+rtl/core
rtl/core/v3n_pkg.sv
rtl/core/v3n_sqrt.sv
rtl/core/v3n_div.sv
rtl/core/vec3_normalize.sv
sim/tb.sv
